/* sv/hbba_pkg.sv */
// hbba_pkg: shared types, constants and codes of the hierarchical bitmap allocator
// no dependencies; imported by the interfaces and all modules but hbba_ram
`timescale 1ns / 1ps

package hbba_pkg;

  // field and register widths
  localparam int ADDR_W    = 48;
  localparam int BSL_W     = 4;
  localparam int CFG_IDX_W = 1;

  // default group index width (bits per level index)
  localparam int GROUP_BITS_DEF = 4;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 1'b1;
  localparam logic [ADDR_W-1:0]    POOL_BASE_RESET     = 48'd4096;
  localparam logic [BSL_W-1:0]     BSL_RESET           = 4'd4;

  // result status codes
  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_NO_FREE      = 3'd1,
    STS_OUTSIDE      = 3'd2,
    STS_MISALIGNED   = 3'd3,
    STS_ALREADY_FREE = 3'd4
  } status_t;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_AL_MID,
    S_AL_LEAF,
    S_AL_ADDR,
    S_FR_CHK,
    S_FR_RMW,
    S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    clr_step;
    logic    latch_in;
    logic    alloc_root;
    logic    alloc_mid;
    logic    alloc_leaf;
    logic    alloc_addr;
    logic    free_sub;
    logic    free_chk;
    logic    free_rmw;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic    op_free;
    logic    req_null;
    logic    root_full;
    logic    mid_none;
    logic    leaf_none;
    status_t chk_code;
    logic    bit_clear;
    logic    clr_last;
    logic    out_free;
  } sts_t;

endpackage

/* sv/hbba_if.sv */
// hbba_if: valid/ready channel interfaces for requests, results and configuration
// depends on hbba_pkg
`timescale 1ns / 1ps

interface hbba_in_if;
  import hbba_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] req_address;
  modport source (output valid, op, req_address, input ready);
  modport sink (input valid, op, req_address, output ready);
endinterface

interface hbba_out_if;
  import hbba_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ADDR_W-1:0] result_address;
  modport source (output valid, status, result_address, input ready);
  modport sink (input valid, status, result_address, output ready);
endinterface

interface hbba_cfg_if;
  import hbba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/hbba_ram.sv */
// hbba_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module hbba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/hbba_ctrl.sv */
// hbba_ctrl: sequencing state machine of the allocator
// depends on hbba_pkg; drives the datapath through cmd_t, reads sts_t
`timescale 1ns / 1ps

module hbba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hbba_pkg::sts_t sts,
  output hbba_pkg::cmd_t cmd
);
  import hbba_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.op_free) begin
          state_nxt = sts.req_null ? S_FINISH : S_FR_CHK;
        end else begin
          state_nxt = sts.root_full ? S_FINISH : S_AL_MID;
        end
      end
      S_AL_MID: begin
        state_nxt = sts.mid_none ? S_FINISH : S_AL_LEAF;
      end
      S_AL_LEAF: begin
        state_nxt = sts.leaf_none ? S_FINISH : S_AL_ADDR;
      end
      S_AL_ADDR: begin
        state_nxt = S_FINISH;
      end
      S_FR_CHK: begin
        state_nxt = (sts.chk_code != STS_OK) ? S_FINISH : S_FR_RMW;
      end
      S_FR_RMW: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_DECODE: begin
        if (sts.op_free) begin
          cmd.free_sub = 1'b1;
          if (sts.req_null) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = STS_OK;
          end
        end else begin
          cmd.alloc_root = 1'b1;
          if (sts.root_full) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = STS_NO_FREE;
          end
        end
      end
      S_AL_MID: begin
        cmd.alloc_mid = 1'b1;
        if (sts.mid_none) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STS_NO_FREE;
        end
      end
      S_AL_LEAF: begin
        cmd.alloc_leaf = 1'b1;
        if (sts.leaf_none) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STS_NO_FREE;
        end
      end
      S_AL_ADDR: begin
        cmd.alloc_addr = 1'b1;
      end
      S_FR_CHK: begin
        cmd.free_chk = 1'b1;
        if (sts.chk_code != STS_OK) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = sts.chk_code;
        end
      end
      S_FR_RMW: begin
        cmd.res_set = 1'b1;
        if (sts.bit_clear) begin
          cmd.res_code = STS_ALREADY_FREE;
        end else begin
          cmd.free_rmw = 1'b1;
          cmd.res_code = STS_OK;
        end
      end
      S_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* sv/hbba_datapath.sv */
// hbba_datapath: bitmap levels, first-zero searches, address checks and result registers
// depends on hbba_pkg and hbba_ram; commanded by hbba_ctrl
`timescale 1ns / 1ps

module hbba_datapath #(
  parameter int GROUP_BITS = hbba_pkg::GROUP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hbba_pkg::cmd_t                  cmd,
  output hbba_pkg::sts_t                  sts,
  input  logic                            in_op,
  input  logic [hbba_pkg::ADDR_W-1:0]     in_req_address,
  input  logic                            cfg_valid,
  input  logic [hbba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbba_pkg::ADDR_W-1:0]     cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hbba_pkg::status_t               out_status,
  output logic [hbba_pkg::ADDR_W-1:0]     out_result_address
);
  import hbba_pkg::*;

  localparam int GB    = GROUP_BITS;
  localparam int G     = 1 << GB;
  localparam int LEAFS = 1 << (2 * GB);
  localparam int IDX_W = 3 * GB;

  // first zero bit of a group word, lowest index wins
  function automatic logic [GB-1:0] lowest_zero(input logic [G-1:0] w);
    logic [GB-1:0] res;
    res = '0;
    for (int i = G - 1; i >= 0; i--) begin
      if (!w[i]) res = GB'(i);
    end
    return res;
  endfunction

  // configuration
  logic [ADDR_W-1:0] pool_base_r;
  logic [BSL_W-1:0]  bsl_r;

  // request and search state
  logic              op_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic [G-1:0]      root_r;
  logic [GB-1:0]     r_r, m_r, bit_r;
  logic [ADDR_W:0]   off_r;
  logic [2*GB-1:0]   clr_cnt_r;

  // result staging and output register
  status_t           res_status_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  // ram ports
  logic            mid_we, mid_re, leaf_we, leaf_re;
  logic [GB-1:0]   mid_waddr, mid_raddr;
  logic [2*GB-1:0] leaf_waddr, leaf_raddr;
  logic [G-1:0]    mid_wdata, mid_rdata, leaf_wdata, leaf_rdata;

  // search and check terms
  logic [GB-1:0]     r_now, m_now, l_now;
  logic [G-1:0]      leaf_set, mid_set;
  logic              leaf_full, mid_full, alloc_ok;
  logic [ADDR_W-1:0] off_shift, align_mask;
  logic [IDX_W-1:0]  idx_now, blk_idx;
  logic              over, misaligned;
  status_t           chk_code;
  logic              out_free;

  assign r_now     = lowest_zero(root_r);
  assign m_now     = lowest_zero(mid_rdata);
  assign l_now     = lowest_zero(leaf_rdata);
  assign leaf_set  = leaf_rdata | (G'(1) << l_now);
  assign mid_set   = mid_rdata | (G'(1) << m_r);
  assign leaf_full = &leaf_set;
  assign mid_full  = &mid_set;
  assign alloc_ok  = cmd.alloc_leaf && !(&leaf_rdata);

  // free address checks on the registered offset
  assign off_shift  = off_r[ADDR_W-1:0] >> bsl_r;
  assign idx_now    = off_shift[IDX_W-1:0];
  assign over       = |off_shift[ADDR_W-1:IDX_W];
  assign align_mask = ~({ADDR_W{1'b1}} << bsl_r);
  assign misaligned = |(off_r[ADDR_W-1:0] & align_mask);
  always_comb begin
    if (off_r[ADDR_W] || over) begin
      chk_code = STS_OUTSIDE;
    end else if (misaligned) begin
      chk_code = STS_MISALIGNED;
    end else begin
      chk_code = STS_OK;
    end
  end

  assign blk_idx  = {r_r, m_r, bit_r};
  assign out_free = !out_valid_r || out_ready;

  // middle level ram port control
  always_comb begin
    mid_re    = cmd.alloc_root || cmd.free_chk;
    mid_raddr = cmd.alloc_root ? r_now : idx_now[IDX_W-1 -: GB];
    mid_we    = cmd.clr_step || (alloc_ok && leaf_full) || cmd.free_rmw;
    mid_waddr = cmd.clr_step ? clr_cnt_r[GB-1:0] : r_r;
    if (cmd.clr_step) begin
      mid_wdata = '0;
    end else if (cmd.alloc_leaf) begin
      mid_wdata = mid_set;
    end else begin
      mid_wdata = mid_rdata & ~(G'(1) << m_r);
    end
  end

  // leaf level ram port control
  always_comb begin
    leaf_re    = cmd.alloc_mid || cmd.free_chk;
    leaf_raddr = cmd.alloc_mid ? {r_r, m_now} : idx_now[IDX_W-1:GB];
    leaf_we    = cmd.clr_step || alloc_ok || cmd.free_rmw;
    leaf_waddr = cmd.clr_step ? clr_cnt_r : {r_r, m_r};
    if (cmd.clr_step) begin
      leaf_wdata = '0;
    end else if (cmd.alloc_leaf) begin
      leaf_wdata = leaf_set;
    end else begin
      leaf_wdata = leaf_rdata & ~(G'(1) << bit_r);
    end
  end

  hbba_ram #(.WIDTH(G), .DEPTH(G)) u_mid_ram (
    .clk   (clk),
    .we    (mid_we),
    .waddr (mid_waddr),
    .wdata (mid_wdata),
    .re    (mid_re),
    .raddr (mid_raddr),
    .rdata (mid_rdata)
  );

  hbba_ram #(.WIDTH(G), .DEPTH(LEAFS)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (leaf_wdata),
    .re    (leaf_re),
    .raddr (leaf_raddr),
    .rdata (leaf_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= POOL_BASE_RESET;
      bsl_r       <= BSL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POOL_BASE:       pool_base_r <= cfg_data;
        CFG_BLOCK_SIZE_LOG2: bsl_r <= cfg_data[BSL_W-1:0];
        default:             pool_base_r <= pool_base_r;
      endcase
    end
  end

  // clearing sweep counter and root level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      root_r    <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (alloc_ok && leaf_full && mid_full) begin
        root_r <= root_r | (G'(1) << r_r);
      end else if (cmd.free_rmw) begin
        root_r <= root_r & ~(G'(1) << r_r);
      end
    end
  end

  // request payload and search indexes
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r       <= in_op;
      req_addr_r <= in_req_address;
    end
    if (cmd.free_sub) begin
      off_r <= {1'b0, req_addr_r} - {1'b0, pool_base_r};
    end
    if (cmd.alloc_root) r_r <= r_now;
    if (cmd.alloc_mid) m_r <= m_now;
    if (cmd.alloc_leaf) bit_r <= l_now;
    if (cmd.free_chk) begin
      r_r   <= idx_now[IDX_W-1 -: GB];
      m_r   <= idx_now[2*GB-1:GB];
      bit_r <= idx_now[GB-1:0];
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_addr_r   <= '0;
    end else if (cmd.alloc_addr) begin
      res_status_r <= STS_OK;
      res_addr_r   <= pool_base_r + (ADDR_W'(blk_idx) << bsl_r);
    end
  end

  // output register, frees the controller while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;

  // status to controller
  always_comb begin
    sts.op_free   = (op_r == OP_FREE);
    sts.req_null  = (req_addr_r == '0);
    sts.root_full = &root_r;
    sts.mid_none  = &mid_rdata;
    sts.leaf_none = &leaf_rdata;
    sts.chk_code  = chk_code;
    sts.bit_clear = !leaf_rdata[bit_r];
    sts.clr_last  = &clr_cnt_r;
    sts.out_free  = out_free;
  end

endmodule

/* sv/hierarchical_bitmap_block_allocator_unit.sv */
// Channel   Dir  Payload                         Transfer
// in_chan   in   op, req_address                 valid && ready
// out_chan  out  status, result_address          valid && ready
// cfg_chan  in   index (0 pool_base, 1 bsl), data valid && ready (ready always high)
//
// An allocate runs decode, mid, leaf and address steps to its result register, a free
// decode, check, update; null free or full pool ends at decode, address fault at check.
// The middle and leaf bitmap rams with registered reads set the sequence of steps.
// After reset a clearing pass zeroes all 2^(2*GROUP_BITS) leaf words, one per cycle,
// before the first request transfer; configuration writes are taken meanwhile.
// A waiting result lets the next request in; a stalled output holds the next result.
// top level of the hierarchical bitmap block allocator
// depends on hbba_pkg, hbba_if, hbba_ctrl and hbba_datapath
`timescale 1ns / 1ps

module hierarchical_bitmap_block_allocator_unit #(
  parameter int GROUP_BITS = hbba_pkg::GROUP_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  hbba_in_if.sink     in_chan,
  hbba_out_if.source  out_chan,
  hbba_cfg_if.sink    cfg_chan
);
  import hbba_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  hbba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hbba_datapath #(.GROUP_BITS(GROUP_BITS)) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_chan.op),
    .in_req_address     (in_chan.req_address),
    .cfg_valid          (cfg_chan.valid),
    .cfg_index          (cfg_chan.index),
    .cfg_data           (cfg_chan.data),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_status         (out_chan.status),
    .out_result_address (out_chan.result_address)
  );

endmodule

/* sv/hbba_checker.sv */
// hbba_checker: port-level assertions of the allocator, bound to the top level
// depends on hbba_pkg and hierarchical_bitmap_block_allocator_unit
`timescale 1ns / 1ps

module hbba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  out_status,
  input logic [hbba_pkg::ADDR_W-1:0] out_result_address
);
  import hbba_pkg::*;

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // an accepted request keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on back-to-back cycles");

  // only a successful allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |-> out_result_address == '0)
    else $error("address on a failed result");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= STS_ALREADY_FREE)
    else $error("undefined status code");

endmodule

bind hierarchical_bitmap_block_allocator_unit hbba_checker u_hbba_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_status         (out_chan.status),
  .out_result_address (out_chan.result_address)
);

/* tb/sv/hbba_alloc_checker.sv */
// hbba_alloc_checker: watches the request, result and register channels of the allocator,
// keeps a shadow of the three bitmap levels and compares every result in order
// depends on hbba_pkg and hbba_if
`timescale 1ns / 1ps

module hbba_alloc_checker #(
  parameter int GROUP_BITS = hbba_pkg::GROUP_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hbba_in_if   req_mon,
  hbba_out_if  rsp_mon,
  hbba_cfg_if  cfg_mon,
  input  logic run_done,
  output int   fail_count,
  output int   pending_count
);
  import hbba_pkg::*;

  localparam int GROUP_W = 1 << GROUP_BITS;
  localparam int LEAF_N  = 1 << (2 * GROUP_BITS);
  localparam int BLOCK_N = 1 << (3 * GROUP_BITS);

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] address;
  } reply_t;

  // shadow bitmaps: full marks above, one bit per block at the leaf level
  logic [GROUP_W-1:0] root_full;
  logic [GROUP_W-1:0] mid_full [GROUP_W];
  logic [GROUP_W-1:0] leaf_used [LEAF_N];
  logic [ADDR_W-1:0]  base_shadow;
  logic [BSL_W-1:0]   bsl_shadow;

  reply_t due_replies [$];
  reply_t head_reply;
  reply_t next_reply;
  int     errors = 0;
  bit     tail_checked = 1'b0;

  assign fail_count = errors;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("[%0t] allocator mismatch: %s", $time, what);
  endtask

  function automatic int lowest_clear(input logic [GROUP_W-1:0] word);
    for (int i = 0; i < GROUP_W; i++) begin
      if (!word[i]) return i;
    end
    return GROUP_W;
  endfunction

  // allocate: lowest free block, full marks pushed upward
  function automatic reply_t take_lowest_block();
    reply_t res;
    int     g;
    int     m;
    int     b;
    int     lw;
    res.status  = STS_NO_FREE;
    res.address = '0;
    g = lowest_clear(root_full);
    if (g >= GROUP_W) return res;
    m = lowest_clear(mid_full[g]);
    if (m >= GROUP_W) return res;
    lw = g * GROUP_W + m;
    b = lowest_clear(leaf_used[lw]);
    if (b >= GROUP_W) return res;
    leaf_used[lw][b] = 1'b1;
    if (&leaf_used[lw]) begin
      mid_full[g][m] = 1'b1;
      if (&mid_full[g]) root_full[g] = 1'b1;
    end
    res.status  = STS_OK;
    res.address = base_shadow + (ADDR_W'(lw * GROUP_W + b) << bsl_shadow);
    return res;
  endfunction

  // free: null, range, alignment, then already-free, in that order
  function automatic status_t release_block(input logic [ADDR_W-1:0] addr);
    logic [63:0] span;
    logic [63:0] offset;
    int          idx;
    int          lw;
    if (addr == '0) return STS_OK;
    span = 64'(BLOCK_N) << bsl_shadow;
    if (addr < base_shadow) return STS_OUTSIDE;
    offset = 64'(addr) - 64'(base_shadow);
    if (offset >= span) return STS_OUTSIDE;
    if ((offset & ((64'd1 << bsl_shadow) - 64'd1)) != 64'd0) return STS_MISALIGNED;
    idx = int'(offset >> bsl_shadow);
    lw  = idx / GROUP_W;
    if (!leaf_used[lw][idx % GROUP_W]) return STS_ALREADY_FREE;
    leaf_used[lw][idx % GROUP_W] = 1'b0;
    mid_full[lw / GROUP_W][lw % GROUP_W] = 1'b0;
    root_full[lw / GROUP_W] = 1'b0;
    return STS_OK;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      root_full = '0;
      foreach (mid_full[i]) mid_full[i] = '0;
      foreach (leaf_used[i]) leaf_used[i] = '0;
      base_shadow = POOL_BASE_RESET;
      bsl_shadow  = BSL_RESET;
      due_replies.delete();
    end else begin
      // register write transfer
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_POOL_BASE) base_shadow = cfg_mon.data;
        else if (cfg_mon.index == CFG_BLOCK_SIZE_LOG2) bsl_shadow = cfg_mon.data[BSL_W-1:0];
      end
      // result transfer against the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d address %h",
                                    rsp_mon.status, rsp_mon.result_address));
        end else begin
          head_reply = due_replies.pop_front();
          if (rsp_mon.status !== head_reply.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_mon.status, head_reply.status));
          if (rsp_mon.result_address !== head_reply.address)
            report_mismatch($sformatf("address %h, expected %h",
                                      rsp_mon.result_address, head_reply.address));
        end
      end
      // request transfer
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.op == OP_ALLOC) begin
          next_reply = take_lowest_block();
        end else begin
          next_reply.status  = release_block(req_mon.req_address);
          next_reply.address = '0;
        end
        due_replies.push_back(next_reply);
      end
      if (run_done && !tail_checked) begin
        tail_checked = 1'b1;
        if (due_replies.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", due_replies.size()));
      end
    end
    pending_count <= due_replies.size();
  end

endmodule

/* tb/sv/tb_hierarchical_bitmap_block_allocator_unit.sv */
// tb_hierarchical_bitmap_block_allocator_unit: drives allocate and free traffic under several
// pool settings, stalls both sides at random and reports the verdict from the checker
// depends on hbba_pkg, hbba_if, hbba_alloc_checker and the allocator top level
`timescale 1ns / 1ps

module tb_hierarchical_bitmap_block_allocator_unit;
  import hbba_pkg::*;

  localparam int BLOCK_TOTAL    = 1 << (3 * GROUP_BITS_DEF);
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic run_done;
  int   fail_count;
  int   pending_count;

  hbba_in_if  in_chan ();
  hbba_out_if out_chan ();
  hbba_cfg_if cfg_chan ();

  // bookkeeping for stimulus: blocks known to be held, ops awaiting their result
  logic [ADDR_W-1:0] cur_base;
  logic [BSL_W-1:0]  cur_bsl;
  int                live_blocks [$];
  bit                in_use [BLOCK_TOTAL];
  logic              ops_in_flight [$];
  bit                src_idle_on;
  bit                sink_idle_on;
  int                quiet_cycles = 0;
  logic              seen_op;
  logic [ADDR_W-1:0] seen_offset;
  int                seen_idx;

  always #5 clk = ~clk;

  hierarchical_bitmap_block_allocator_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  hbba_alloc_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (in_chan),
    .rsp_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .run_done      (run_done),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** hierarchical_bitmap_block_allocator_unit: FAILED **");
      $finish;
    end
  end

  // track which blocks the allocator has handed out
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready && ops_in_flight.size() != 0) begin
      seen_op = ops_in_flight.pop_front();
      if (seen_op == OP_ALLOC && out_chan.status == STS_OK) begin
        seen_offset = out_chan.result_address - cur_base;
        seen_idx = int'((seen_offset >> cur_bsl) & ADDR_W'(BLOCK_TOTAL - 1));
        if (!in_use[seen_idx]) begin
          in_use[seen_idx] = 1'b1;
          live_blocks.push_back(seen_idx);
        end
      end
    end
    if (rst_n && in_chan.valid && in_chan.ready) ops_in_flight.push_back(in_chan.op);
  end

  // result side back-pressure in random bursts
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_idle_on && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] block_addr(input int idx);
    return cur_base + (ADDR_W'(idx) << cur_bsl);
  endfunction

  // one request transfer, with an optional gap ahead of it
  task automatic send_req(input logic op, input logic [ADDR_W-1:0] addr);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.op          <= op;
    in_chan.req_address <= addr;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // both registers, written back to back once the block is idle
  task automatic configure(input logic [ADDR_W-1:0] base, input logic [BSL_W-1:0] bsl);
    logic [ADDR_W-1:0] bsl_word;
    wait_drained();
    bsl_word = rand_addr();
    bsl_word[BSL_W-1:0] = bsl;
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= CFG_POOL_BASE;
    cfg_chan.data  <= base;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    cfg_chan.index <= CFG_BLOCK_SIZE_LOG2;
    cfg_chan.data  <= bsl_word;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    cfg_chan.valid <= 1'b0;
    cur_base = base;
    cur_bsl  = bsl;
  endtask

  task automatic free_random_live();
    int                k;
    int                idx;
    logic [ADDR_W-1:0] addr;
    k    = $urandom_range(0, live_blocks.size() - 1);
    idx  = live_blocks[k];
    addr = block_addr(idx);
    // a wrapped or null address cannot release the block, so it stays held
    if (addr >= cur_base && addr != '0) begin
      live_blocks.delete(k);
      in_use[idx] = 1'b0;
    end
    send_req(OP_FREE, addr);
  endtask

  // mostly frees of held blocks and allocates, some bad addresses
  task automatic random_traffic(input int count, input int alloc_pct);
    int                pick;
    int                idx;
    logic [ADDR_W-1:0] addr;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        send_req(OP_ALLOC, rand_addr());
      end else if (pick < alloc_pct + 30 && live_blocks.size() != 0) begin
        free_random_live();
      end else if (pick < alloc_pct + 36) begin
        idx = $urandom_range(0, BLOCK_TOTAL - 1);
        if (in_use[idx]) send_req(OP_ALLOC, rand_addr());
        else send_req(OP_FREE, block_addr(idx));
      end else if (pick < alloc_pct + 39) begin
        send_req(OP_FREE, '0);
      end else begin
        case ($urandom_range(0, 3))
          0: addr = rand_addr();
          1: begin
            if (cur_bsl == '0) addr = rand_addr();
            else addr = block_addr($urandom_range(0, BLOCK_TOTAL - 1)) +
                        ADDR_W'($urandom_range(1, (1 << cur_bsl) - 1));
          end
          2: addr = cur_base - ADDR_W'($urandom_range(1, 64));
          default: addr = cur_base + (ADDR_W'(BLOCK_TOTAL) << cur_bsl) +
                          ADDR_W'($urandom_range(0, 64));
        endcase
        send_req(OP_FREE, addr);
      end
      if ($urandom_range(0, 249) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    run_done            <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.op          <= OP_ALLOC;
    in_chan.req_address <= '0;
    cfg_chan.valid      <= 1'b0;
    cfg_chan.index      <= CFG_POOL_BASE;
    cfg_chan.data       <= '0;
    cur_base     = POOL_BASE_RESET;
    cur_bsl      = BSL_RESET;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default pool, every status code but no-free
    configure(POOL_BASE_RESET, BSL_RESET);
    repeat (3) send_req(OP_ALLOC, '0);
    send_req(OP_FREE, '0);
    send_req(OP_FREE, cur_base - 48'd1);
    send_req(OP_FREE, block_addr(BLOCK_TOTAL));
    send_req(OP_FREE, block_addr(BLOCK_TOTAL) - 48'd1);
    send_req(OP_FREE, cur_base + 48'd1);
    send_req(OP_FREE, block_addr(5));
    send_req(OP_FREE, block_addr(1));
    send_req(OP_FREE, block_addr(1));
    send_req(OP_FREE, '1);
    send_req(OP_FREE, block_addr(BLOCK_TOTAL - 1));
    // hold the sender until every result is back
    wait_drained();
    send_req(OP_ALLOC, '1);
    send_req(OP_FREE, block_addr(0));
    send_req(OP_ALLOC, rand_addr());
    random_traffic(200, 45);

    // zero base, byte blocks: block 0 sits at the null address
    configure('0, '0);
    send_req(OP_FREE, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_FREE, '0);
    src_idle_on  = ($urandom_range(0, 1) == 1);
    sink_idle_on = ($urandom_range(0, 1) == 1);
    random_traffic(120, 45);

    // top base with the largest shift, allocated addresses wrap
    configure('1, 4'd15);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b1;
    random_traffic(120, 45);

    configure(48'd1, 4'd12);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b0;
    random_traffic(120, 45);

    configure(rand_addr(), BSL_W'($urandom_range(0, 15)));
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    random_traffic(200, 45);

    configure(rand_addr() & ~48'hFFF, BSL_W'($urandom_range(4, 12)));
    random_traffic(230, 55);

    // last stretch without idling
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    random_traffic(250, 30);

    wait_drained();
    repeat (20) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("** hierarchical_bitmap_block_allocator_unit: PASSED **");
    end else begin
      $display("** hierarchical_bitmap_block_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
